// ===== hw/rtl/sto_pkg.sv =====
// Shared constants for the sorted timeout queue: operation codes, register
// indexes, field widths and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sto_pkg;

  localparam int TIME_W       = 31;
  localparam int NOW_W        = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int SLOTS_DEF    = 256;
  localparam int HANDLER_DEF  = 16;
  localparam int TAG_DEF      = 32;

  localparam logic [TIME_W-1:0] TIME_MAX       = {TIME_W{1'b1}};
  localparam logic [TIME_W-1:0] THRESHOLD_RST  = TIME_W'(10);
  localparam logic [TIME_W-1:0] EMPTY_WAIT_RST = {TIME_W{1'b1}};

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_CREATE  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_HANDLE  = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_WAIT = CFG_IDX_W'(1);

endpackage
`default_nettype wire

// ===== hw/rtl/sto_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sto_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read registered; a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_timeout_queue_unit.sv =====
// Sorted timeout queue: top level with sequencer, slot RAMs and link RAM.
// Depends on sto_pkg and sto_ram.
`timescale 1ns / 1ps
`default_nettype none
// A pool of SLOTS timer events held as a linked list sorted by remaining
// time, with unused slots on a free chain; all slot data sits in RAMs with a
// registered read, walked by one sequencer one entry per clock. Restart
// rebuilds the link RAM; the same rebuild runs after reset, with the input
// stalled until it ends. Create and handle with reinsertion walk the queue
// up to the insert point; advance walks every entry. One word is worked on
// at a time; the result register lets the next word in while a result is
// still waiting on out_stall.
module sorted_timeout_queue_unit #(
  parameter int SLOTS        = sto_pkg::SLOTS_DEF,
  parameter int HANDLER_BITS = sto_pkg::HANDLER_DEF,
  parameter int TAG_BITS     = sto_pkg::TAG_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     operation,
  input  wire logic [sto_pkg::NOW_W-1:0]      now_time,
  input  wire logic [sto_pkg::TIME_W-1:0]     timeout,
  input  wire logic [sto_pkg::TIME_W-1:0]     period,
  input  wire logic [HANDLER_BITS-1:0]        handler,
  input  wire logic [TAG_BITS-1:0]            tag,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                accepted,
  output logic      [sto_pkg::TIME_W-1:0]     next_wait,
  output logic                                fired,
  output logic      [HANDLER_BITS-1:0]        fired_handler,
  output logic      [TAG_BITS-1:0]            fired_tag,
  // configuration
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [sto_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sto_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int TW    = sto_pkg::TIME_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CRT_RD, S_HND_RD, S_ADV, S_WALK, S_WALK_CMP,
    S_LINK1, S_LINK2, S_FIN
  } state_t;

  state_t state;

  // configuration registers
  logic [TW-1:0] expire_threshold;
  logic [TW-1:0] empty_wait;

  // queue control
  logic [IDX_W-1:0] queue_head, free_head;
  logic [CNT_W-1:0] queue_count, free_count;
  logic [sto_pkg::NOW_W-1:0] last_time;
  logic [IDX_W-1:0] clr_idx;
  logic             restart_reply;

  // walk registers
  logic [IDX_W-1:0] cur, prev, ins_slot;
  logic             has_prev;
  logic [CNT_W-1:0] walk_n;
  logic [TW-1:0]    key;
  logic [TW-1:0]    dt;

  // latched input word
  logic [TW-1:0]           tmo_in, per_in;
  logic [HANDLER_BITS-1:0] hnd_in;
  logic [TAG_BITS-1:0]     tag_in;

  // pending result
  logic                    r_accepted, r_fired;
  logic [TW-1:0]           r_wait;
  logic [HANDLER_BITS-1:0] r_handler;
  logic [TAG_BITS-1:0]     r_tag;

  // RAM ports
  logic [IDX_W-1:0]        rd_addr, wr_addr;
  logic                    rem_we, per_we, hnd_we, tag_we, link_we;
  logic [TW-1:0]           rem_wd, rem_q, per_q;
  logic [HANDLER_BITS-1:0] hnd_q;
  logic [TAG_BITS-1:0]     tag_q;
  logic [IDX_W-1:0]        link_wd, link_q;

  // elapsed time, saturated
  logic [sto_pkg::NOW_W-1:0] diff;
  logic [TW-1:0]             dt_sat;
  logic [TW-1:0]             rem_dec;
  logic                      in_take;
  logic                      out_free;
  logic                      last_walk;

  assign diff     = now_time - last_time;
  assign dt_sat   = (|diff[sto_pkg::NOW_W-1:TW]) ? sto_pkg::TIME_MAX : diff[TW-1:0];
  assign rem_dec  = (rem_q > dt) ? rem_q - dt : '0;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign last_walk = (walk_n + CNT_W'(1)) == queue_count;
  assign in_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  sto_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_rem (
    .clk(clk), .we(rem_we), .waddr(wr_addr), .wdata(rem_wd),
    .raddr(rd_addr), .rdata(rem_q));
  sto_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_per (
    .clk(clk), .we(per_we), .waddr(wr_addr), .wdata(per_in),
    .raddr(rd_addr), .rdata(per_q));
  sto_ram #(.WIDTH(HANDLER_BITS), .DEPTH(SLOTS)) u_hnd (
    .clk(clk), .we(hnd_we), .waddr(wr_addr), .wdata(hnd_in),
    .raddr(rd_addr), .rdata(hnd_q));
  sto_ram #(.WIDTH(TAG_BITS), .DEPTH(SLOTS)) u_tag (
    .clk(clk), .we(tag_we), .waddr(wr_addr), .wdata(tag_in),
    .raddr(rd_addr), .rdata(tag_q));
  sto_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_link (
    .clk(clk), .we(link_we), .waddr(wr_addr), .wdata(link_wd),
    .raddr(rd_addr), .rdata(link_q));

  // read address: next entry of a walk comes straight from the link word
  always_comb begin
    unique case (state)
      S_IDLE:     rd_addr = (operation == sto_pkg::OP_CREATE) ? free_head : queue_head;
      S_WALK:     rd_addr = queue_head;
      S_WALK_CMP: rd_addr = link_q;
      S_ADV:      rd_addr = link_q;
      default:    rd_addr = cur;
    endcase
  end

  // RAM writes
  always_comb begin
    wr_addr = cur;
    rem_we  = 1'b0;
    rem_wd  = rem_dec;
    per_we  = 1'b0;
    hnd_we  = 1'b0;
    tag_we  = 1'b0;
    link_we = 1'b0;
    link_wd = cur;
    unique case (state)
      S_CLEAR: begin
        wr_addr = clr_idx;
        link_we = 1'b1;
        link_wd = (clr_idx == LAST_IDX) ? '0 : clr_idx + IDX_W'(1);
      end
      S_CRT_RD: begin
        wr_addr = free_head;
        rem_we  = 1'b1;
        rem_wd  = tmo_in;
        per_we  = 1'b1;
        hnd_we  = 1'b1;
        tag_we  = 1'b1;
      end
      S_HND_RD: begin
        wr_addr = cur;
        if (rem_q < expire_threshold) begin
          if (per_q == '0) begin
            link_we = 1'b1;
            link_wd = free_head;
          end else begin
            rem_we = 1'b1;
            rem_wd = per_q;
          end
        end
      end
      S_ADV: begin
        wr_addr = cur;
        rem_we  = 1'b1;
        rem_wd  = rem_dec;
      end
      S_LINK1: begin
        wr_addr = ins_slot;
        link_we = 1'b1;
        link_wd = cur;
      end
      S_LINK2: begin
        wr_addr = prev;
        link_we = 1'b1;
        link_wd = ins_slot;
      end
      default: ;
    endcase
  end

  // sequencer, queue state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_idx          <= '0;
      restart_reply    <= 1'b0;
      queue_head       <= '0;
      queue_count      <= '0;
      free_head        <= '0;
      free_count       <= CNT_W'(SLOTS);
      last_time        <= '0;
      expire_threshold <= sto_pkg::THRESHOLD_RST;
      empty_wait       <= sto_pkg::EMPTY_WAIT_RST;
      out_valid        <= 1'b0;
    end else begin
      // S_FIN reloads the result register itself
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sto_pkg::REG_THRESHOLD) begin
          expire_threshold <= cfg_data[TW-1:0];
        end else if (cfg_index == sto_pkg::REG_EMPTY_WAIT) begin
          empty_wait <= cfg_data[TW-1:0];
        end
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_idx == LAST_IDX) begin
            // a restart answers with a word, the rebuild after reset does not
            clr_idx       <= '0;
            restart_reply <= 1'b0;
            state         <= restart_reply ? S_FIN : S_IDLE;
          end else begin
            clr_idx <= clr_idx + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (in_take) begin
            r_accepted <= 1'b0;
            r_fired    <= 1'b0;
            r_wait     <= '0;
            r_handler  <= '0;
            r_tag      <= '0;
            tmo_in     <= timeout;
            per_in     <= period;
            hnd_in     <= handler;
            tag_in     <= tag;
            cur        <= queue_head;
            walk_n     <= '0;
            unique case (sto_pkg::op_t'(operation))
              sto_pkg::OP_RESTART: begin
                last_time     <= now_time;
                queue_head    <= '0;
                queue_count   <= '0;
                free_head     <= '0;
                free_count    <= CNT_W'(SLOTS);
                clr_idx       <= '0;
                restart_reply <= 1'b1;
                state         <= S_CLEAR;
              end
              sto_pkg::OP_CREATE: begin
                state <= (free_count == '0) ? S_FIN : S_CRT_RD;
              end
              sto_pkg::OP_ADVANCE: begin
                last_time <= now_time;
                dt        <= dt_sat;
                if (queue_count == '0) begin
                  r_wait <= empty_wait;
                  state  <= S_FIN;
                end else begin
                  state <= S_ADV;
                end
              end
              sto_pkg::OP_HANDLE: begin
                state <= (queue_count == '0) ? S_FIN : S_HND_RD;
              end
            endcase
          end
        end
        S_CRT_RD: begin
          ins_slot   <= free_head;
          free_head  <= link_q;
          free_count <= free_count - CNT_W'(1);
          key        <= tmo_in;
          r_accepted <= 1'b1;
          state      <= S_WALK;
        end
        S_HND_RD: begin
          if (rem_q < expire_threshold) begin
            queue_head  <= link_q;
            queue_count <= queue_count - CNT_W'(1);
            r_fired     <= 1'b1;
            r_handler   <= hnd_q;
            r_tag       <= tag_q;
            if (per_q == '0) begin
              free_head  <= cur;
              free_count <= free_count + CNT_W'(1);
              state      <= S_FIN;
            end else begin
              ins_slot <= cur;
              key      <= per_q;
              state    <= S_WALK;
            end
          end else begin
            state <= S_FIN;
          end
        end
        S_ADV: begin
          if (walk_n == '0) begin
            r_wait <= rem_dec;
          end
          cur    <= link_q;
          walk_n <= walk_n + CNT_W'(1);
          if (last_walk) begin
            state <= S_FIN;
          end
        end
        S_WALK: begin
          cur      <= queue_head;
          walk_n   <= '0;
          has_prev <= 1'b0;
          state    <= (queue_count == '0) ? S_LINK1 : S_WALK_CMP;
        end
        S_WALK_CMP: begin
          if (rem_q <= key) begin
            prev     <= cur;
            has_prev <= 1'b1;
            cur      <= link_q;
            walk_n   <= walk_n + CNT_W'(1);
            if (last_walk) begin
              state <= S_LINK1;
            end
          end else begin
            state <= S_LINK1;
          end
        end
        S_LINK1: begin
          if (has_prev) begin
            state <= S_LINK2;
          end else begin
            queue_head  <= ins_slot;
            queue_count <= queue_count + CNT_W'(1);
            state       <= S_FIN;
          end
        end
        S_LINK2: begin
          queue_count <= queue_count + CNT_W'(1);
          state       <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            accepted      <= r_accepted;
            next_wait     <= r_wait;
            fired         <= r_fired;
            fired_handler <= r_handler;
            fired_tag     <= r_tag;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // slot accounting is whole whenever the sequencer rests
  a_slot_sum: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (queue_count + free_count) == CNT_W'(SLOTS))
    else $error("queue and free counts do not add up to the pool size");

  // insert at the front moves the head onto the new slot
  a_front_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK1 && !has_prev) |=> queue_head == $past(ins_slot))
    else $error("front insert did not update the queue head");

  // a result word carries the answer of one operation only
  a_one_answer: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(accepted && fired) && !(fired && next_wait != '0))
    else $error("result word mixes answers of two operations");

  // a walk never runs past the end of the queue
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_CMP || state == S_ADV) |-> walk_n < queue_count)
    else $error("list walk ran past the queue count");

endmodule
`default_nettype wire
